/* hdl/mau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, command codes, sequencer states and divider interface types.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int RESIDUE_WIDTH_DEF = 31;
  localparam int OPERAND_WIDTH     = 32;
  localparam int CMD_WIDTH         = 3;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4,
    CMD_NEG = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_MUL,
    ST_INV_DIV,
    ST_INV_UPD,
    ST_INV_FIX,
    ST_POW_STEP,
    ST_POW_SQR,
    ST_DONE
  } state_t;

  // Start strobe, busy flag and finish strobe between sequencer and shared divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage : mau_pkg
`default_nettype wire

/* hdl/mau_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module mau_divider #(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output mau_pkg::div_ctl_t  ctl,
  output logic      [DW-1:0] quotient,
  output logic      [DW-1:0] remainder
);
  import mau_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem, quo[DW-1]};
    trial   = shifted - {1'b0, dvs};
  end

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
  assign quotient  = quo;
  assign remainder = rem;

`ifndef NO_ASSERTIONS
  // A finish strobe only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without busy");
  // Never restarted while running
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("divider restarted while busy");
  // Remainder stays below divisor once finished
  a_rem_small: assert property (@(posedge clk) disable iff (rst)
    (done && dvs != '0) |-> rem < dvs) else $error("remainder not reduced");
`endif

endmodule : mau_divider
`default_nettype wire

/* hdl/modular_arithmetic_unit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, divide, power and negate modulo a set modulus.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// in        sink       in_valid, in_stall, command, operand_a, operand_b
// out       source     out_valid, out_stall, result, error
// cfg       sink       cfg_we, cfg_data (modulus)
//
// Each request passes through one shared restoring divider (width
// D = max(RESIDUE_WIDTH+1, 32)) and one shift-and-add multiplier. Both
// operands are reduced by the divider, then the dispatch state runs. Add,
// subtract, negate: the result is formed in dispatch. Multiply: one product
// more. Power: one step state and up to two products per exponent bit, 32
// bits at most. Divide: one division and one product per Euclid step plus a
// final product.
// Reset is synchronous; the modulus returns to 1000000007.
// in_stall is high from acceptance until the result is taken.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_top #(
  parameter int RESIDUE_WIDTH = mau_pkg::RESIDUE_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [RESIDUE_WIDTH-1:0]        cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mau_pkg::CMD_WIDTH-1:0]   command,
  input  wire logic [mau_pkg::OPERAND_WIDTH-1:0] operand_a,
  input  wire logic [mau_pkg::OPERAND_WIDTH-1:0] operand_b,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [RESIDUE_WIDTH-1:0]             result,
  output logic                                 error
);
  import mau_pkg::*;

  localparam int RW  = RESIDUE_WIDTH;
  localparam int DW  = (RW + 1 > OPERAND_WIDTH) ? RW + 1 : OPERAND_WIDTH;
  localparam int EW  = OPERAND_WIDTH;
  localparam int ECW = $clog2(EW + 1);
  localparam int MCW = $clog2(RW + 1);

  // Registers
  logic [RW-1:0]  modulus;
  state_t         state, state_next;
  cmd_t           cmd;
  logic [DW-1:0]  a_raw, b_raw;
  logic [RW-1:0]  m_eff;
  logic [RW-1:0]  a, b;
  logic [EW-1:0]  expo;
  logic [RW-1:0]  acc;
  logic [RW-1:0]  base;
  // Shift-and-add multiplier
  logic [RW-1:0]  mx, my, macc;
  logic [MCW-1:0] mcnt;
  logic           mbusy;
  logic           msel;    // 0 accumulator product, 1 square
  // Euclid
  logic [DW-1:0]  r0, r1;
  logic [RW:0]    c0, c1;  // signed, magnitude below m
  logic [RW-1:0]  res;
  logic           err;
  logic           div_start;
  logic [DW-1:0]  div_dividend, div_divisor, quo, rem;
  div_ctl_t       dctl;

  // Shared modular adder for the multiplier
  function automatic logic [RW-1:0] addm(input logic [RW-1:0] x, input logic [RW-1:0] y,
                                         input logic [RW-1:0] m);
    logic [RW:0] s;
    begin
      s = {1'b0, x} + {1'b0, y};
      addm = (s >= {1'b0, m}) ? RW'(s - {1'b0, m}) : s[RW-1:0];
    end
  endfunction

  mau_divider #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .ctl       (dctl),
    .quotient  (quo),
    .remainder (rem)
  );

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET[RW-1:0];
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  logic         accept;
  logic         mul_req;   // start a product on the next edge
  logic [RW:0]  cm;
  assign accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = a_raw;
    div_divisor  = {{(DW-RW){1'b0}}, m_eff};
    mul_req      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_RED_A;
      end
      ST_RED_A: begin
        if (!dctl.busy && !dctl.done) begin
          div_start = 1'b1;
        end else if (dctl.done) begin
          state_next = ST_RED_B;
        end
      end
      ST_RED_B: begin
        div_dividend = b_raw;
        if (!dctl.busy && !dctl.done) begin
          div_start = 1'b1;
        end else if (dctl.done) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (cmd == CMD_MUL) begin
          mul_req = 1'b1;
          state_next = ST_MUL;
        end else if (cmd == CMD_DIV) begin
          state_next = (m_eff == RW'(1) || b == '0) ? ST_DONE : ST_INV_DIV;
        end else if (cmd == CMD_POW) begin
          state_next = ST_POW_STEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MUL: begin
        if (!mbusy) state_next = ST_DONE;
      end
      ST_INV_DIV: begin
        div_dividend = r0;
        div_divisor  = r1;
        if (!dctl.busy && !dctl.done) begin
          div_start = 1'b1;
        end else if (dctl.done) begin
          mul_req    = 1'b1;
          state_next = ST_INV_UPD;
        end
      end
      ST_INV_UPD: begin
        if (!mbusy) begin
          state_next = (rem == '0) ? ST_INV_FIX : ST_INV_DIV;
          mul_req    = (rem == '0) && (r1 == DW'(1));
        end
      end
      ST_INV_FIX: begin
        if (!mbusy) state_next = ST_DONE;
      end
      ST_POW_STEP: begin
        if (!mbusy) begin
          state_next = (expo == '0) ? ST_DONE : ST_POW_SQR;
          mul_req    = (expo != '0);
        end
      end
      ST_POW_SQR: begin
        if (!mbusy) begin
          if (!msel) begin
            mul_req = 1'b1;
          end else begin
            state_next = ST_POW_STEP;
          end
        end
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // c0 - q*c1 reduced: |c| < m, so work modulo m on nonnegative forms
  logic [RW-1:0] c1_pos;
  logic [RW-1:0] c0_pos;
  assign cm     = {1'b0, m_eff};
  assign c1_pos = c1[RW] ? RW'(c1 + cm) : c1[RW-1:0];
  assign c0_pos = c0[RW] ? RW'(c0 + cm) : c0[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mbusy     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= (state_next == ST_DONE);
      // Start a product on request, drop busy once the multiplier runs dry
      if (mbusy) begin
        if (my == '0 || mcnt == '0) mbusy <= 1'b0;
      end else begin
        mbusy <= mul_req;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= cmd_t'(command);
      a_raw <= DW'(operand_a);
      b_raw <= DW'(operand_b);
      expo  <= operand_b;
      m_eff <= (modulus < RW'(2)) ? RW'(1) : modulus;
      err   <= 1'b0;
      res   <= '0;
    end
    // Shift-and-add step
    if (mbusy) begin
      if (my[0]) macc <= addm(macc, mx, m_eff);
      mx   <= addm(mx, mx, m_eff);
      my   <= my >> 1;
      mcnt <= mcnt - 1'b1;
    end
    unique case (state)
      ST_RED_A: if (dctl.done) a <= rem[RW-1:0];
      ST_RED_B: if (dctl.done) b <= rem[RW-1:0];
      ST_DISPATCH: begin
        mx <= a; my <= b; macc <= '0; mcnt <= MCW'(RW);
        acc  <= (m_eff == RW'(1)) ? '0 : RW'(1);
        base <= a;
        r0 <= {{(DW-RW){1'b0}}, m_eff};
        r1 <= {{(DW-RW){1'b0}}, b};
        c0 <= '0; c1 <= (RW+1)'(1);
        unique case (cmd)
          CMD_ADD: res <= addm(a, b, m_eff);
          CMD_SUB: res <= (a >= b) ? RW'(a - b) : RW'(a + (m_eff - b));
          CMD_NEG: res <= (a == '0) ? '0 : RW'(m_eff - a);
          CMD_DIV: begin
            res <= '0;
            err <= (m_eff != RW'(1)) && (b == '0);
          end
          default: res <= '0;
        endcase
      end
      ST_MUL: if (!mbusy) res <= macc;
      ST_INV_DIV: if (dctl.done) begin
        // q*c1 mod m via shift-and-add: q never exceeds m, one subtract reduces it
        mx <= c1_pos;
        my <= (quo >= {{(DW-RW){1'b0}}, m_eff}) ? RW'(quo - {{(DW-RW){1'b0}}, m_eff})
                                                : quo[RW-1:0];
        macc <= '0;
        mcnt <= MCW'(RW);
      end
      ST_INV_UPD: if (!mbusy) begin
        r0 <= r1; r1 <= rem;
        c0 <= c1;
        c1 <= {1'b0, (c0_pos >= macc) ? RW'(c0_pos - macc) : RW'(c0_pos + (m_eff - macc))};
        if (rem == '0) begin
          if (r1 != DW'(1)) begin
            err <= 1'b1; res <= '0;
          end else begin
            mx <= a; my <= c1_pos; macc <= '0; mcnt <= MCW'(RW);
          end
        end
      end
      ST_INV_FIX: if (!mbusy && !err) res <= macc;
      ST_POW_STEP: if (!mbusy) begin
        if (expo != '0) begin
          macc <= '0; mcnt <= MCW'(RW);
          if (expo[0]) begin
            mx <= acc; my <= base; msel <= 1'b0;
          end else begin
            mx <= base; my <= base; msel <= 1'b1;
          end
        end else begin
          res <= acc;
        end
      end
      ST_POW_SQR: if (!mbusy) begin
        if (!msel) begin
          // Fold the product in, then square the base
          acc <= macc;
          mx <= base; my <= base; macc <= '0; mcnt <= MCW'(RW); msel <= 1'b1;
        end else begin
          base <= macc;
          expo <= expo >> 1;
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign result   = res;
  assign error    = err;

`ifndef NO_ASSERTIONS
  // Result only offered in the finishing state
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_DONE) else $error("valid outside done");
  // Result below the modulus
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res < m_eff) else $error("result not reduced");
  // Error only on divide
  a_err_div: assert property (@(posedge clk) disable iff (rst)
    (out_valid && err) |-> cmd == CMD_DIV) else $error("error on non-divide");
`endif

endmodule : modular_arithmetic_unit_top
`default_nettype wire
